// File: hdl/salru_pkg.sv
// Package for the set-associative LRU cache simulator.
// Holds request/response payload structs, request and CSR codes, and field widths.
// No dependencies.
`timescale 1ns / 1ps

package salru_pkg;

   localparam int ADDR_W     = 64;
   localparam int CNT_W      = 32;
   localparam int STAMP_W    = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_STORE  = 2'd1;
   localparam logic [1:0] REQ_MODIFY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS       = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ADDR_W-1:0] address;
   } salru_req_type;

   typedef struct packed {
      logic             hit;
      logic             evicted;
      logic             last;
      logic [CNT_W-1:0] hits_total;
      logic [CNT_W-1:0] misses_total;
      logic [CNT_W-1:0] evictions_total;
   } salru_rsp_type;

endpackage

// File: hdl/salru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the cache set array; no package dependencies.
`timescale 1ns / 1ps

module salru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/set_assoc_cache_lru_sim.sv
// Top level of the set-associative cache simulator with LRU replacement.
// Depends on salru_pkg and salru_ram (one row per set holds all ways).
//
// After reset the block sweeps the set RAM, one set per cycle (2**floor(log2(MAX_SETS))
// rows, 256 by default) with busy high; CSR writes are taken throughout. An access then
// keeps busy high through the write-back of its set row, and no new start is taken before
// then; the single tag/stamp comparator visits the ways in turn, up to the hit way, or all
// configured ways on a miss. A modify request runs two accesses, one after the other.
// Each result appears for one cycle with rsp_valid, the cycle after the set row is written
// back; the receiver cannot stall it.
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim
   import salru_pkg::*;
#(
   parameter int MAX_SETS  = 256,
   parameter int MAX_WAYS  = 8,
   parameter int ADDR_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  salru_req_type         req_data,
   output logic                  rsp_valid,
   output salru_rsp_type         rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SMAX   = $clog2(MAX_SETS + 1) - 1;
   localparam int DEPTH  = 2 ** SMAX;
   localparam int TAG_W  = ADDR_BITS - 2;
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam logic [SMAX-1:0] SET_ONES = {SMAX{1'b1}};

   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   state_type          state_ff, state_in;
   logic [SMAX-1:0]    clr_addr_ff, clr_addr_in;
   logic [SMAX-1:0]    set_ff, set_in;
   logic [TAG_W-1:0]   tag_ff, tag_in;
   logic               two_ff, two_in;
   logic               second_ff, second_in;
   logic [WAY_W-1:0]   j_ff, j_in;
   logic [WAY_W-1:0]   sel_way_ff, sel_way_in;
   logic               hit_ff, hit_in;
   logic               victim_valid_ff, victim_valid_in;
   logic [STAMP_W-1:0] min_stamp_ff, min_stamp_in;
   logic [STAMP_W-1:0] next_stamp_ff, next_stamp_in;
   logic [CNT_W-1:0]   hits_ff, hits_in;
   logic [CNT_W-1:0]   misses_ff, misses_in;
   logic [CNT_W-1:0]   evicts_ff, evicts_in;
   logic               rsp_valid_ff, rsp_valid_in;
   salru_rsp_type      rsp_ff, rsp_in;
   logic [3:0]         set_bits_ff;
   logic [4:0]         block_bits_ff;
   logic [3:0]         ways_ff;

   logic                 accept;
   logic [4:0]           sb_eff;
   logic [4:0]           bb_eff;
   logic [5:0]           tag_shift;
   logic [ADDR_BITS-1:0] addr_used;
   logic [ADDR_BITS-1:0] addr_sh;
   logic [ADDR_BITS-1:0] tag_sh;
   logic [SMAX-1:0]      set_mask;
   logic [SMAX-1:0]      set_comb;
   logic [WAY_W-1:0]     ways_last;
   logic                 tag_match;
   line_type             cur_line;
   row_type              row_rd;
   row_type              wr_row;
   logic                 ram_wr_en;
   logic [SMAX-1:0]      ram_wr_addr;
   row_type              ram_wr_data;
   logic                 ram_rd_en;
   logic [SMAX-1:0]      ram_rd_addr;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // effective split, clamped to the supported ranges
   always_comb begin
      if (set_bits_ff == 4'd0) begin
         sb_eff = 5'd1;
      end else if ({1'b0, set_bits_ff} > 5'(SMAX)) begin
         sb_eff = 5'(SMAX);
      end else begin
         sb_eff = {1'b0, set_bits_ff};
      end
      bb_eff = (block_bits_ff == 5'd0) ? 5'd1 : block_bits_ff;
      if (ways_ff == 4'd0) begin
         ways_last = '0;
      end else if (32'(ways_ff) > MAX_WAYS) begin
         ways_last = WAY_W'(MAX_WAYS - 1);
      end else begin
         ways_last = WAY_W'(ways_ff - 4'd1);
      end
   end

   assign tag_shift = 6'(sb_eff) + 6'(bb_eff);
   assign addr_used = req_data.address[ADDR_BITS-1:0];
   assign addr_sh   = addr_used >> bb_eff;
   assign tag_sh    = addr_used >> tag_shift;
   assign set_mask  = ~(SET_ONES << sb_eff);
   assign set_comb  = addr_sh[SMAX-1:0] & set_mask;

   assign cur_line  = row_rd[j_ff];
   assign tag_match = cur_line.valid && (cur_line.tag == tag_ff);

   always_comb begin
      wr_row = row_rd;
      for (int k = 0; k < MAX_WAYS; k++) begin
         if (WAY_W'(k) == sel_way_ff) begin
            wr_row[k].stamp = next_stamp_ff;
            if (!hit_ff) begin
               wr_row[k].valid = 1'b1;
               wr_row[k].tag   = tag_ff;
            end
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      clr_addr_in     = clr_addr_ff;
      set_in          = set_ff;
      tag_in          = tag_ff;
      two_in          = two_ff;
      second_in       = second_ff;
      j_in            = j_ff;
      sel_way_in      = sel_way_ff;
      hit_in          = hit_ff;
      victim_valid_in = victim_valid_ff;
      min_stamp_in    = min_stamp_ff;
      next_stamp_in   = next_stamp_ff;
      hits_in         = hits_ff;
      misses_in       = misses_ff;
      evicts_in       = evicts_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = set_ff;
      ram_wr_data     = wr_row;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = set_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == SET_ONES) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = set_comb;
               set_in      = set_comb;
               tag_in      = tag_sh[TAG_W-1:0];
               two_in      = (req_data.req_type == REQ_MODIFY);
               second_in   = 1'b0;
               j_in        = '0;
               hit_in      = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            j_in      = '0;
            hit_in    = 1'b0;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (tag_match) begin
               hit_in     = 1'b1;
               sel_way_in = j_ff;
               state_in   = ST_WRITE;
            end else begin
               if ((j_ff == '0) || (cur_line.stamp < min_stamp_ff)) begin
                  min_stamp_in    = cur_line.stamp;
                  sel_way_in      = j_ff;
                  victim_valid_in = cur_line.valid;
               end
               if (j_ff == ways_last) begin
                  state_in = ST_WRITE;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         ST_WRITE: begin
            ram_wr_en     = 1'b1;
            next_stamp_in = next_stamp_ff + 1'b1;
            if (hit_ff) begin
               hits_in = sat_inc(hits_ff);
            end else begin
               misses_in = sat_inc(misses_ff);
               if (victim_valid_ff) begin
                  evicts_in = sat_inc(evicts_ff);
               end
            end
            rsp_valid_in           = 1'b1;
            rsp_in.hit             = hit_ff;
            rsp_in.evicted         = !hit_ff && victim_valid_ff;
            rsp_in.last            = !(two_ff && !second_ff);
            rsp_in.hits_total      = hits_in;
            rsp_in.misses_total    = misses_in;
            rsp_in.evictions_total = evicts_in;
            if (two_ff && !second_ff) begin
               second_in = 1'b1;
               state_in  = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         next_stamp_ff <= STAMP_W'(1);
         hits_ff       <= '0;
         misses_ff     <= '0;
         evicts_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         two_ff        <= 1'b0;
         second_ff     <= 1'b0;
         set_bits_ff   <= 4'd1;
         block_bits_ff <= 5'd1;
         ways_ff       <= 4'd1;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         next_stamp_ff <= next_stamp_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         evicts_ff     <= evicts_in;
         rsp_valid_ff  <= rsp_valid_in;
         two_ff        <= two_in;
         second_ff     <= second_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SET_BITS:   set_bits_ff   <= csr_wdata[3:0];
               CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
               CSR_WAYS:       ways_ff       <= csr_wdata[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      set_ff          <= set_in;
      tag_ff          <= tag_in;
      j_ff            <= j_in;
      sel_way_ff      <= sel_way_in;
      hit_ff          <= hit_in;
      victim_valid_ff <= victim_valid_in;
      min_stamp_ff    <= min_stamp_in;
      rsp_ff          <= rsp_in;
   end

   salru_ram #(
      .WIDTH ($bits(row_type)),
      .DEPTH (DEPTH)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (row_rd)
   );

   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_WRITE))
      else $error("response without a row write-back");

   a_start_to_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted transfer did not start a set scan");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> !rsp_data.evicted)
      else $error("eviction reported on a hit");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff <= ways_last))
      else $error("way scan ran past the configured ways");

endmodule

// File: dv/salru_checker.sv
// Scoreboard for the set-associative LRU cache simulator: watches the request, result and
// CSR transfers, predicts each access outcome from its own cache model and compares.
// Depends on salru_pkg.
`timescale 1ns / 1ps

module salru_checker
   import salru_pkg::*;
#(
   parameter int NUM_SETS = 256,
   parameter int NUM_WAYS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  salru_req_type         req_data,
   input  logic                  rsp_valid,
   input  salru_rsp_type         rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int unsigned           mismatches,
   output int unsigned           outstanding
);

   localparam int NUM_LINES    = NUM_SETS * NUM_WAYS;
   localparam int SET_BITS_MAX = $clog2(NUM_SETS + 1) - 1;

   logic               line_valid [NUM_LINES];
   logic [ADDR_W-1:0]  line_tag   [NUM_LINES];
   logic [STAMP_W-1:0] line_stamp [NUM_LINES];
   logic [STAMP_W-1:0] stamp_next;
   logic [CNT_W-1:0]   hit_cnt;
   logic [CNT_W-1:0]   miss_cnt;
   logic [CNT_W-1:0]   evict_cnt;
   logic [3:0]         cfg_sets;
   logic [4:0]         cfg_block;
   logic [3:0]         cfg_ways;
   salru_rsp_type      predicted_outcomes [$];
   int unsigned        fail_count;

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   task automatic lookup_and_fill(input logic [ADDR_W-1:0] addr, input logic is_last);
      int unsigned   sb;
      int unsigned   bb;
      int unsigned   ways;
      int unsigned   base;
      int unsigned   victim;
      logic [ADDR_W-1:0] set_idx;
      logic [ADDR_W-1:0] tag;
      salru_rsp_type r;
      sb     = (cfg_sets == 0) ? 1 : ((cfg_sets > SET_BITS_MAX) ? SET_BITS_MAX : cfg_sets);
      bb     = (cfg_block == 0) ? 1 : cfg_block;
      ways   = (cfg_ways == 0) ? 1 : ((cfg_ways > NUM_WAYS) ? NUM_WAYS : cfg_ways);
      set_idx = (addr >> bb) & ((64'd1 << sb) - 64'd1);
      tag     = addr >> (sb + bb);
      base    = 32'(set_idx) * NUM_WAYS;
      r       = '0;
      r.last  = is_last;
      for (int j = 0; j < ways && !r.hit; j++) begin
         if (line_valid[base + j] && line_tag[base + j] == tag) begin
            line_stamp[base + j] = stamp_next;
            stamp_next = stamp_next + 1'b1;
            hit_cnt = bump(hit_cnt);
            r.hit = 1'b1;
         end
      end
      if (!r.hit) begin
         miss_cnt = bump(miss_cnt);
         victim = 0;
         for (int j = 1; j < ways; j++) begin
            if (line_stamp[base + j] < line_stamp[base + victim]) victim = j;
         end
         victim += base;
         if (line_valid[victim]) begin
            r.evicted = 1'b1;
            evict_cnt = bump(evict_cnt);
         end
         line_stamp[victim] = stamp_next;
         stamp_next = stamp_next + 1'b1;
         line_tag[victim]   = tag;
         line_valid[victim] = 1'b1;
      end
      r.hits_total      = hit_cnt;
      r.misses_total    = miss_cnt;
      r.evictions_total = evict_cnt;
      predicted_outcomes.push_back(r);
   endtask

   task automatic check_outcome(input salru_rsp_type got);
      salru_rsp_type want;
      if (predicted_outcomes.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result with none pending: hit=%0b evicted=%0b last=%0b", $realtime,
                     got.hit, got.evicted, got.last);
      end else begin
         want = predicted_outcomes.pop_front();
         if (got.hit !== want.hit || got.evicted !== want.evicted || got.last !== want.last ||
             got.hits_total !== want.hits_total || got.misses_total !== want.misses_total ||
             got.evictions_total !== want.evictions_total) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("%0t: result mismatch", $realtime);
               $display("   expected hit=%0b evicted=%0b last=%0b hits=%0d misses=%0d evict=%0d",
                        want.hit, want.evicted, want.last, want.hits_total,
                        want.misses_total, want.evictions_total);
               $display("   actual   hit=%0b evicted=%0b last=%0b hits=%0d misses=%0d evict=%0d",
                        got.hit, got.evicted, got.last, got.hits_total,
                        got.misses_total, got.evictions_total);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LINES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_stamp[i] = '0;
         end
         stamp_next = 1;
         hit_cnt    = '0;
         miss_cnt   = '0;
         evict_cnt  = '0;
         cfg_sets   = 4'd1;
         cfg_block  = 5'd1;
         cfg_ways   = 4'd1;
         fail_count = 0;
         predicted_outcomes.delete();
      end else begin
         if (rsp_valid) check_outcome(rsp_data);
         if (start && !busy) begin
            if (req_data.req_type == REQ_MODIFY) begin
               lookup_and_fill(req_data.address, 1'b0);
               lookup_and_fill(req_data.address, 1'b1);
            end else begin
               lookup_and_fill(req_data.address, 1'b1);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SET_BITS:   cfg_sets  = csr_wdata[3:0];
               CSR_BLOCK_BITS: cfg_block = csr_wdata;
               CSR_WAYS:       cfg_ways  = csr_wdata[3:0];
               default: ;
            endcase
         end
      end
      mismatches  <= fail_count;
      outstanding <= predicted_outcomes.size();
   end

endmodule

// File: dv/tb_set_assoc_cache_lru_sim.sv
// Testbench top for the set-associative LRU cache simulator: reset, CSR phases, directed
// and random access stimulus, and the final verdict.
// Depends on salru_pkg, set_assoc_cache_lru_sim and salru_checker.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_sim;
   import salru_pkg::*;

   localparam logic [1:0]           REQ_UNKNOWN = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = 2'd3;
   localparam int                   NUM_PHASES  = 8;
   localparam int                   PHASE_ITEMS = 170;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   salru_req_type         req_data  = '0;
   logic                  csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  busy;
   logic                  rsp_valid;
   salru_rsp_type         rsp_data;
   logic                  csr_ready;
   int unsigned           mismatches;
   int unsigned           outstanding;

   int unsigned idle_pct  = 28;
   int unsigned eff_sets  = 1;
   int unsigned eff_block = 1;
   int unsigned eff_ways  = 1;

   logic [4:0] phase_sets  [NUM_PHASES] = '{5'd0, 5'd8, 5'd15, 5'd19, 5'd2, 5'd1, 5'd0, 5'd0};
   logic [4:0] phase_block [NUM_PHASES] = '{5'd0, 5'd16, 5'd31, 5'd5, 5'd2, 5'd1, 5'd0, 5'd0};
   logic [4:0] phase_ways  [NUM_PHASES] = '{5'd0, 5'd8, 5'd15, 5'd4, 5'd2, 5'd1, 5'd0, 5'd0};

   always #1 clock = ~clock;

   set_assoc_cache_lru_sim i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   salru_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   task automatic send_access(input logic [1:0] kind, input logic [ADDR_W-1:0] addr);
      salru_req_type item;
      item.req_type = kind;
      item.address  = addr;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      while ($urandom_range(0, 99) < idle_pct) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // drop start, then wait for the last result and for the block to go idle
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [4:0] sb, input logic [4:0] bb, input logic [4:0] wy);
      write_reg(CSR_SET_BITS, sb);
      write_reg(CSR_BLOCK_BITS, bb);
      write_reg(CSR_WAYS, wy);
      csr_valid <= 1'b0;
      eff_sets  = (sb[3:0] == 0) ? 1 : ((sb[3:0] > 8) ? 8 : sb[3:0]);
      eff_block = (bb == 0) ? 1 : bb;
      eff_ways  = (wy[3:0] == 0) ? 1 : ((wy[3:0] > 8) ? 8 : wy[3:0]);
   endtask

   // small tag pool over a few sets, so lines get reused, replaced and hit again
   function automatic logic [ADDR_W-1:0] shaped_addr();
      logic [ADDR_W-1:0] tag;
      logic [ADDR_W-1:0] set_idx;
      logic [ADDR_W-1:0] offset;
      tag = $urandom_range(0, eff_ways + 3);
      if ($urandom_range(0, 15) == 0) tag = tag ^ ({$urandom, $urandom} >> (eff_sets + eff_block));
      set_idx = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
      set_idx = set_idx & ((64'd1 << eff_sets) - 64'd1);
      offset  = {$urandom, $urandom} & ((64'd1 << eff_block) - 64'd1);
      return (tag << (eff_sets + eff_block)) | (set_idx << eff_block) | offset;
   endfunction

   initial begin
      logic [4:0]        sb;
      logic [4:0]        bb;
      logic [4:0]        wy;
      logic [1:0]        kind;
      logic [ADDR_W-1:0] addr;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset config: one set bit, one block bit, one way
      send_access(REQ_LOAD,    64'h0);
      send_access(REQ_STORE,   64'h1);
      send_access(REQ_MODIFY,  64'h0);
      send_access(REQ_MODIFY,  64'h4);
      send_access(REQ_LOAD,    64'h2);
      send_access(REQ_UNKNOWN, '1);
      send_access(REQ_STORE,   64'h8000_0000_0000_0000);
      send_access(REQ_MODIFY,  '1);
      send_access(REQ_LOAD,    64'h5555_5555_5555_5555);
      send_access(REQ_STORE,   64'hAAAA_AAAA_AAAA_AAAA);
      send_access(REQ_UNKNOWN, 64'h6);
      send_access(REQ_LOAD,    64'h0);
      settle();

      write_reg(CSR_SPARE, 5'h1F);
      for (int p = 0; p < NUM_PHASES; p++) begin
         sb = (p < 6) ? phase_sets[p]  : 5'($urandom_range(0, 31));
         bb = (p < 6) ? phase_block[p] : 5'($urandom_range(0, 31));
         wy = (p < 6) ? phase_ways[p]  : 5'($urandom_range(0, 31));
         configure(sb, bb, wy);
         idle_pct = (p == 3) ? 0 : 28;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            kind = 2'($urandom_range(0, 3));
            addr = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : shaped_addr();
            send_access(kind, addr);
         end
         settle();
      end

      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("tb_set_assoc_cache_lru_sim: clean");
      else
         $display("tb_set_assoc_cache_lru_sim: errors");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("tb_set_assoc_cache_lru_sim: errors");
      $finish;
   end

endmodule

// File: files.f
hdl/salru_pkg.sv
hdl/salru_ram.sv
hdl/set_assoc_cache_lru_sim.sv
dv/salru_checker.sv
dv/tb_set_assoc_cache_lru_sim.sv
